// ===== rtl/pnc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnc_pkg
// Shared constants and types of the perfect number classifier.
// ----------------------------------------------------------------------------
package pnc_pkg;

  localparam int NUMBER_WIDTH_DEF = 16;
  localparam int DSUM_W           = 19;
  localparam int CLASS_W          = 2;

  localparam logic [DSUM_W-1:0]  SUM_MAX = {DSUM_W{1'b1}};

  localparam logic [CLASS_W-1:0] CLASS_PERFECT   = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_ABUNDANT  = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_DEFICIENT = 2'd2;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } pnc_div_status_t;

  typedef struct packed {
    logic [CLASS_W-1:0] number_class;
    logic [DSUM_W-1:0]  divisor_sum;
  } pnc_result_t;

endpackage

// ===== rtl/pnc_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnc_divider
// Restoring bit-serial divider, one quotient bit per cycle; reports whether
// the remainder is zero.
// ----------------------------------------------------------------------------
module pnc_divider
  import pnc_pkg::*;
#(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [NUMBER_WIDTH-1:0] dividend,
  input  logic [NUMBER_WIDTH-1:0] divisor,
  output pnc_div_status_t         status
);

  localparam int CNT_W = $clog2(NUMBER_WIDTH + 1);

  logic                    busy_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [NUMBER_WIDTH-1:0] rem_r;
  logic [NUMBER_WIDTH-1:0] dvd_r;
  logic [NUMBER_WIDTH-1:0] dsr_r;

  logic [NUMBER_WIDTH:0]   rem_sh;
  logic                    fits;
  logic [NUMBER_WIDTH-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[NUMBER_WIDTH-1]};
    fits    = rem_sh >= {1'b0, dsr_r};
    rem_nxt = fits ? NUMBER_WIDTH'(rem_sh - {1'b0, dsr_r}) : rem_sh[NUMBER_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NUMBER_WIDTH);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_r << 1;
    end
  end

  // last step: remainder is final
  assign status.done     = busy_r && (cnt_r == CNT_W'(1));
  assign status.rem_zero = (rem_nxt == '0);

endmodule

// ===== rtl/pnc_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnc_seq
// Steps the trial divisor, drives the single divider, accumulates the
// divisor sum and classifies the number.
// ----------------------------------------------------------------------------
module pnc_seq
  import pnc_pkg::*;
#(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [NUMBER_WIDTH-1:0] in_number,
  output logic                    idle,
  output logic                    res_valid,
  input  logic                    res_ready,
  output pnc_result_t             res,
  output logic                    div_start,
  output logic [NUMBER_WIDTH-1:0] div_dividend,
  output logic [NUMBER_WIDTH-1:0] div_divisor,
  input  pnc_div_status_t         div_status
);

  // proper divisor sum stays below 8 * number
  localparam int SUM_W = NUMBER_WIDTH + 3;
  localparam int EXT_W = (SUM_W > DSUM_W) ? SUM_W : DSUM_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_START  = 4'b0010,
    ST_WAIT   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [NUMBER_WIDTH-1:0] n_r, n_nxt;
  logic [NUMBER_WIDTH-1:0] d_r, d_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;

  logic [SUM_W-1:0]        n_ext;
  logic [EXT_W-1:0]        sum_ext;

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    sum_nxt   = sum_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          n_nxt   = in_number;
          d_nxt   = NUMBER_WIDTH'(1);
          sum_nxt = '0;
          // zero and one have no trial divisor
          state_nxt = (in_number < NUMBER_WIDTH'(2)) ? ST_FINISH : ST_START;
        end
      end
      ST_START: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_status.done) begin
          if (div_status.rem_zero) begin
            sum_nxt = sum_r + SUM_W'(d_r);
          end
          if (d_r == n_r - NUMBER_WIDTH'(1)) begin
            state_nxt = ST_FINISH;
          end else begin
            d_nxt     = d_r + NUMBER_WIDTH'(1);
            state_nxt = ST_START;
          end
        end
      end
      ST_FINISH: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    sum_r <= sum_nxt;
  end

  assign idle         = (state_r == ST_IDLE);
  assign res_valid    = (state_r == ST_FINISH);
  assign div_start    = (state_r == ST_START);
  assign div_dividend = n_r;
  assign div_divisor  = d_r;

  always_comb begin
    n_ext   = SUM_W'(n_r);
    sum_ext = EXT_W'(sum_r);
    if (sum_r == n_ext) begin
      res.number_class = CLASS_PERFECT;
    end else if (sum_r > n_ext) begin
      res.number_class = CLASS_ABUNDANT;
    end else begin
      res.number_class = CLASS_DEFICIENT;
    end
    res.divisor_sum = (sum_ext > EXT_W'(SUM_MAX)) ? SUM_MAX : DSUM_W'(sum_ext);
  end

endmodule

// ===== rtl/perfect_number_classifier_top.sv =====
`timescale 1ns / 1ps
// 0 and 1 go straight to the result; other numbers try each divisor from 1 to number - 1
// each trial divisor costs an issue state plus NUMBER_WIDTH steps of the serial divider
// one request at a time
// a finished result waits in the output register while the next request is taken
// reset (synchronous, active low) returns the sequencer to idle and drops out_valid
// ----------------------------------------------------------------------------
// perfect_number_classifier_top
// Classifies a number as perfect, abundant or deficient by trial division.
// ----------------------------------------------------------------------------
module perfect_number_classifier_top
  import pnc_pkg::*;
#(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [NUMBER_WIDTH-1:0] in_number,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CLASS_W-1:0]      out_number_class,
  output logic [DSUM_W-1:0]       out_divisor_sum
);

  logic                    seq_idle;
  logic                    res_valid;
  logic                    res_ready;
  pnc_result_t             res;
  logic                    div_start;
  logic [NUMBER_WIDTH-1:0] div_dividend;
  logic [NUMBER_WIDTH-1:0] div_divisor;
  pnc_div_status_t         div_status;

  logic                    out_valid_r;
  pnc_result_t             out_res_r;

  pnc_seq #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_number   (in_number),
    .idle        (seq_idle),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .div_start   (div_start),
    .div_dividend(div_dividend),
    .div_divisor (div_divisor),
    .div_status  (div_status)
  );

  pnc_divider #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .status  (div_status)
  );

  // output register is free when empty or being drained
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign in_stall         = !seq_idle;
  assign out_valid        = out_valid_r;
  assign out_number_class = out_res_r.number_class;
  assign out_divisor_sum  = out_res_r.divisor_sum;

endmodule

// ===== rtl/pnc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnc_checker
// Port-level checks on the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module pnc_checker
  import pnc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [CLASS_W-1:0] out_number_class,
  input logic [DSUM_W-1:0]  out_divisor_sum
);

  // one request in flight: busy right after taking one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepting a request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_number_class) && $stable(out_divisor_sum))
    else $error("stalled result changed");

  a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_number_class == CLASS_PERFECT) ||
                  (out_number_class == CLASS_ABUNDANT) ||
                  (out_number_class == CLASS_DEFICIENT))
    else $error("unused class code on output");

  // abundant needs a sum above the number, so it cannot be zero
  a_abundant_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_number_class == CLASS_ABUNDANT) |-> out_divisor_sum != '0)
    else $error("abundant result with zero divisor sum");

endmodule

bind perfect_number_classifier_top pnc_checker u_pnc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_number_class(out_number_class),
  .out_divisor_sum (out_divisor_sum)
);
